// File: hdl/msgpk_pkg.sv
// ----------------------------------------------------------------------------
// msgpk_pkg
// Shared types and codes for the MessagePack value encoder.
// ----------------------------------------------------------------------------
package msgpk_pkg;

  // Input action codes.
  localparam logic [2:0] ACT_NULL  = 3'd0;
  localparam logic [2:0] ACT_BOOL  = 3'd1;
  localparam logic [2:0] ACT_INT   = 3'd2;
  localparam logic [2:0] ACT_FLOAT = 3'd3;
  localparam logic [2:0] ACT_STR   = 3'd4;
  localparam logic [2:0] ACT_ARRAY = 3'd5;
  localparam logic [2:0] ACT_MAP   = 3'd6;
  localparam logic [2:0] ACT_RAW   = 3'd7;

  // MessagePack tag bytes.
  localparam logic [7:0] TAG_NIL     = 8'hc0;
  localparam logic [7:0] TAG_FALSE   = 8'hc2;
  localparam logic [7:0] TAG_TRUE    = 8'hc3;
  localparam logic [7:0] TAG_FLOAT64 = 8'hcb;
  localparam logic [7:0] TAG_UINT8   = 8'hcc;
  localparam logic [7:0] TAG_UINT16  = 8'hcd;
  localparam logic [7:0] TAG_UINT32  = 8'hce;
  localparam logic [7:0] TAG_UINT64  = 8'hcf;
  localparam logic [7:0] TAG_INT8    = 8'hd0;
  localparam logic [7:0] TAG_INT16   = 8'hd1;
  localparam logic [7:0] TAG_INT32   = 8'hd2;
  localparam logic [7:0] TAG_INT64   = 8'hd3;
  localparam logic [7:0] TAG_FIXSTR  = 8'ha0;
  localparam logic [7:0] TAG_STR8    = 8'hd9;
  localparam logic [7:0] TAG_STR16   = 8'hda;
  localparam logic [7:0] TAG_STR32   = 8'hdb;
  localparam logic [7:0] TAG_FIXARR  = 8'h90;
  localparam logic [7:0] TAG_ARR16   = 8'hdc;
  localparam logic [7:0] TAG_ARR32   = 8'hdd;
  localparam logic [7:0] TAG_FIXMAP  = 8'h80;
  localparam logic [7:0] TAG_MAP16   = 8'hde;
  localparam logic [7:0] TAG_MAP32   = 8'hdf;

  // One encoded item: tag byte, then count content bytes taken from the
  // top of data (left aligned, most significant byte first).
  typedef struct packed {
    logic [7:0]  tag;
    logic [63:0] data;
    logic [3:0]  count;
  } frame_t;

endpackage

// File: hdl/msgpk_encode.sv
// ----------------------------------------------------------------------------
// msgpk_encode
// Classifies one input item into its tag and content bytes and holds the
// result in a one-entry frame register.
// ----------------------------------------------------------------------------
module msgpk_encode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            action,
  input  logic signed [63:0]    value,
  input  logic [30:0]           length,
  input  logic [7:0]            payload_byte,
  output logic                  f_valid,
  input  logic                  f_ready,
  output msgpk_pkg::frame_t     frame
);
  import msgpk_pkg::*;

  frame_t      frame_next;
  logic [63:0] u;
  logic [31:0] len32;

  assign u        = value;
  assign len32    = {1'b0, length};
  assign in_ready = !f_valid || f_ready;

  always_comb begin
    frame_next.tag   = TAG_NIL;
    frame_next.data  = '0;
    frame_next.count = 4'd0;
    case (action)
      ACT_NULL: begin
        frame_next.tag = TAG_NIL;
      end
      ACT_BOOL: begin
        frame_next.tag = (u != 64'd0) ? TAG_TRUE : TAG_FALSE;
      end
      ACT_INT: begin
        if (!u[63]) begin
          if (u[63:7] == '0) begin
            frame_next.tag = u[7:0];
          end else if (u[63:8] == '0) begin
            frame_next.tag   = TAG_UINT8;
            frame_next.data  = {u[7:0], 56'd0};
            frame_next.count = 4'd1;
          end else if (u[63:16] == '0) begin
            frame_next.tag   = TAG_UINT16;
            frame_next.data  = {u[15:0], 48'd0};
            frame_next.count = 4'd2;
          end else if (u[63:32] == '0) begin
            frame_next.tag   = TAG_UINT32;
            frame_next.data  = {u[31:0], 32'd0};
            frame_next.count = 4'd4;
          end else begin
            frame_next.tag   = TAG_UINT64;
            frame_next.data  = u;
            frame_next.count = 4'd8;
          end
        end else begin
          // Negative values: the sign extension above each form's width
          // must be all ones for that form to hold the value.
          if (&u[63:5]) begin
            frame_next.tag = u[7:0];
          end else if (&u[63:7]) begin
            frame_next.tag   = TAG_INT8;
            frame_next.data  = {u[7:0], 56'd0};
            frame_next.count = 4'd1;
          end else if (&u[63:15]) begin
            frame_next.tag   = TAG_INT16;
            frame_next.data  = {u[15:0], 48'd0};
            frame_next.count = 4'd2;
          end else if (&u[63:31]) begin
            frame_next.tag   = TAG_INT32;
            frame_next.data  = {u[31:0], 32'd0};
            frame_next.count = 4'd4;
          end else begin
            frame_next.tag   = TAG_INT64;
            frame_next.data  = u;
            frame_next.count = 4'd8;
          end
        end
      end
      ACT_FLOAT: begin
        frame_next.tag   = TAG_FLOAT64;
        frame_next.data  = u;
        frame_next.count = 4'd8;
      end
      ACT_STR: begin
        if (length[30:5] == '0) begin
          frame_next.tag = TAG_FIXSTR | {3'd0, length[4:0]};
        end else if (length[30:8] == '0) begin
          frame_next.tag   = TAG_STR8;
          frame_next.data  = {len32[7:0], 56'd0};
          frame_next.count = 4'd1;
        end else if (length[30:16] == '0) begin
          frame_next.tag   = TAG_STR16;
          frame_next.data  = {len32[15:0], 48'd0};
          frame_next.count = 4'd2;
        end else begin
          frame_next.tag   = TAG_STR32;
          frame_next.data  = {len32, 32'd0};
          frame_next.count = 4'd4;
        end
      end
      ACT_ARRAY, ACT_MAP: begin
        if (length[30:4] == '0) begin
          frame_next.tag = ((action == ACT_ARRAY) ? TAG_FIXARR : TAG_FIXMAP)
                           | {4'd0, length[3:0]};
        end else if (length[30:16] == '0) begin
          frame_next.tag   = (action == ACT_ARRAY) ? TAG_ARR16 : TAG_MAP16;
          frame_next.data  = {len32[15:0], 48'd0};
          frame_next.count = 4'd2;
        end else begin
          frame_next.tag   = (action == ACT_ARRAY) ? TAG_ARR32 : TAG_MAP32;
          frame_next.data  = {len32, 32'd0};
          frame_next.count = 4'd4;
        end
      end
      ACT_RAW: begin
        frame_next.tag = payload_byte;
      end
      default: begin
        frame_next.tag = TAG_NIL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame <= frame_next;
    end
  end

endmodule

// File: hdl/msgpk_serial.sv
// ----------------------------------------------------------------------------
// msgpk_serial
// Sends a frame out one byte per transaction: the tag, then the content
// bytes most significant first, with last set on the final byte.
// ----------------------------------------------------------------------------
module msgpk_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              f_valid,
  output logic              f_ready,
  input  msgpk_pkg::frame_t frame,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              last
);
  import msgpk_pkg::*;

  logic [63:0] data;
  logic [3:0]  remain;

  assign last    = (remain == 4'd0);
  // A new frame loads when the block is empty or its final byte leaves now.
  assign f_ready = !out_valid || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      remain    <= 4'd0;
    end else if (f_ready) begin
      out_valid <= f_valid;
      if (f_valid) begin
        remain <= frame.count;
      end
    end else if (out_ready) begin
      remain <= remain - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready) begin
      if (f_valid) begin
        out_byte <= frame.tag;
        data     <= frame.data;
      end
    end else if (out_ready) begin
      out_byte <= data[63:56];
      data     <= {data[55:0], 8'd0};
    end
  end

endmodule

// File: hdl/msgpack_value_encoder.sv
// ----------------------------------------------------------------------------
// msgpack_value_encoder
// Encodes one typed value per input transaction into its MessagePack bytes.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload
//   --------+----------------------+--------------------------------------
//   input   | in_valid / in_ready  | action, value, length, payload_byte
//   output  | out_valid / out_ready| out_byte, last
//
// An item is held in the encode register, then sent on the byte-wide output
// port as one tag byte plus 0, 1, 2, 4 or 8 content bytes.
// The output port sets the sustained rate, one byte per cycle while out_ready
// stays high; the next item waits in the encode register while the current
// one is sent. Reset is synchronous and clears both valid flags and remain.
// A stall on out_ready holds the current byte and backs up into in_ready.
module msgpack_value_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [63:0] value,
  input  logic [30:0]        length,
  input  logic [7:0]         payload_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               last
);
  import msgpk_pkg::*;

  logic   f_valid;
  logic   f_ready;
  frame_t frame;

  msgpk_encode u_encode (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .value        (value),
    .length       (length),
    .payload_byte (payload_byte),
    .f_valid      (f_valid),
    .f_ready      (f_ready),
    .frame        (frame)
  );

  msgpk_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .frame     (frame),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

  // An accepted input transaction always lands in the encode register.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> f_valid)
    else $error("accepted item did not reach the encode register");

  // A frame waiting for the serializer is held unchanged.
  a_frame_held: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |=> f_valid && $stable(frame))
    else $error("pending frame changed while stalled");

  // Content byte count is one of the legal MessagePack widths.
  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> (frame.count == 4'd0 || frame.count == 4'd1 ||
                 frame.count == 4'd2 || frame.count == 4'd4 ||
                 frame.count == 4'd8))
    else $error("illegal content byte count");

  // After the final byte leaves with nothing pending, the output goes idle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last && !f_valid |=> !out_valid)
    else $error("output stayed valid after the final byte");

endmodule
